@@ sv/bitmap_first_fit_allocator_core_defines.svh @@
// assertion macros shared by the allocator rtl
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

// property checked at every clock edge out of reset
`define BFFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define BFFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bffa_pkg.sv @@
// types and constants of the bitmap first-fit allocator
package bffa_pkg;

  localparam int unsigned ENTRY_W         = 14;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned BIT_W           = 6;
  localparam int unsigned MAX_ENTRIES_DEF = 8192;
  localparam logic [ENTRY_W-1:0] CFG_RESET = 14'd8192;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [ENTRY_W-1:0] entry_number;
  } req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] allocated_number;
    status_e            status;
    logic [ENTRY_W-1:0] free_count;
  } rsp_t;

endpackage

@@ sv/bffa_ifs.sv @@
// valid/ready channel interfaces of the allocator

// command requests
interface bffa_req_if;
  logic             valid;
  logic             ready;
  bffa_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// command responses
interface bffa_rsp_if;
  logic             valid;
  logic             ready;
  bffa_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// entry count register writes
interface bffa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bffa_pkg::ENTRY_W-1:0]     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/bffa_ram.sv @@
// generic single write, single read ram with registered read data
module bffa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bitmap_first_fit_allocator_core.sv @@
// bitmap first-fit allocator: usage map in ram, scan and read-modify-write sequencer
//
//   port    dir  modport  payload
//   cfg_i   in   sink     entry count (14 bits)
//   req_i   in   sink     cmd, entry_number
//   rsp_o   out  source   allocated_number, status, free_count
//
// allocate: map words scanned one per cycle from word 0, at most ceil(entries/64),
//   limited by the single read port of the map ram
// free: read, check and write back, response; out-of-range requests skip the read
// one request at a time; the response register frees the input side while it waits
// reset and entry count writes clear the map through a fill mark, no clearing pass
// a stalled response holds the sequencer in its response state until taken
`include "bitmap_first_fit_allocator_core_defines.svh"

module bitmap_first_fit_allocator_core #(
  parameter int unsigned MAX_ENTRIES = bffa_pkg::MAX_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bffa_cfg_if.sink   cfg_i,
  bffa_req_if.sink   req_i,
  bffa_rsp_if.source rsp_o
);

  localparam int unsigned ENTRY_W = bffa_pkg::ENTRY_W;
  localparam int unsigned WORD_W  = bffa_pkg::WORD_W;
  localparam int unsigned BIT_W   = bffa_pkg::BIT_W;
  localparam int unsigned WORDS   = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned FILL_W  = $clog2(WORDS + 1);
  localparam logic [ENTRY_W-1:0] N_RST =
    (bffa_pkg::CFG_RESET > MAX_ENTRIES) ? ENTRY_W'(MAX_ENTRIES) : bffa_pkg::CFG_RESET;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FCHK = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  // lowest set bit of a map word
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (v[b]) p = BIT_W'(b);
    end
    return p;
  endfunction

  // entry count clipped to the map size
  function automatic logic [ENTRY_W-1:0] clip(input logic [ENTRY_W-1:0] v);
    return (32'(v) > MAX_ENTRIES) ? ENTRY_W'(MAX_ENTRIES) : v;
  endfunction

  state_e                state_q, state_d;
  logic [ENTRY_W-1:0]    n_q, n_d;
  logic [ENTRY_W-1:0]    free_cnt_q, free_cnt_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic                  fresh_q, fresh_d;
  logic [BIT_W-1:0]      idx_q, idx_d;
  logic [ENTRY_W-1:0]    res_num_q, res_num_d;
  bffa_pkg::status_e     res_status_q, res_status_d;
  bffa_pkg::rsp_t        out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  mem_we, mem_re;
  logic [ROW_W-1:0]      mem_raddr;
  logic [WORD_W-1:0]     mem_wdata, mem_rdata;

  logic [ENTRY_W-1:0]    n_m1, last_sh, num_m1, num_sh;
  logic [ROW_W-1:0]      last_row, free_row, next_row;
  logic [BIT_W-1:0]      lim, pos, bsel;
  logic [WORD_W-1:0]     word, vmask, avail;
  logic                  found, req_acc, cfg_acc, resp_load;

  // map word storage
  bffa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (row_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // handshakes
  assign cfg_i.ready = (state_q == S_IDLE);
  assign req_i.ready = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // response register takes a new response
  assign resp_load   = (state_q == S_RESP) && (!out_valid_q || rsp_o.ready);

  // geometry of the entries in use
  assign n_m1     = n_q - ENTRY_W'(1);
  assign last_sh  = n_m1 >> BIT_W;
  assign last_row = last_sh[ROW_W-1:0];
  assign lim      = n_m1[BIT_W-1:0];
  assign num_m1   = req_i.data.entry_number - ENTRY_W'(1);
  assign num_sh   = num_m1 >> BIT_W;
  assign free_row = num_sh[ROW_W-1:0];
  assign next_row = row_q + ROW_W'(1);
  assign bsel     = idx_q;

  // current word: rows at or past the fill mark read as clear
  assign word = fresh_q ? '0 : mem_rdata;

  // bits past the last entry never count as free
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      vmask[b] = (row_q != last_row) || (BIT_W'(b) <= lim);
    end
  end

  assign avail = ~word & vmask;
  assign found = |avail;
  assign pos   = first_set(avail);

  // sequencer
  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    free_cnt_d   = free_cnt_q;
    fill_d       = fill_q;
    row_d        = row_q;
    fresh_d      = fresh_q;
    idx_d        = idx_q;
    res_num_d    = res_num_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = row_q;
    mem_wdata    = word;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_acc) begin
          n_d        = clip(cfg_i.data);
          free_cnt_d = clip(cfg_i.data);
          fill_d     = '0;
        end else if (req_acc) begin
          res_num_d    = '0;
          res_status_d = bffa_pkg::ST_OK;
          if (req_i.data.cmd == bffa_pkg::CMD_ALLOC) begin
            if (n_q == '0) begin
              res_status_d = bffa_pkg::ST_FULL;
              state_d      = S_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              row_d     = '0;
              fresh_d   = (fill_q == '0);
              state_d   = S_SCAN;
            end
          end else begin
            if ((req_i.data.entry_number == '0) || (req_i.data.entry_number > n_q)) begin
              res_status_d = bffa_pkg::ST_RANGE;
              state_d      = S_RESP;
            end else begin
              idx_d     = num_m1[BIT_W-1:0];
              mem_re    = 1'b1;
              mem_raddr = free_row;
              row_d     = free_row;
              fresh_d   = (FILL_W'(free_row) >= fill_q);
              state_d   = S_FCHK;
            end
          end
        end
      end

      S_SCAN: begin
        if (found) begin
          mem_we    = 1'b1;
          mem_wdata = word | (WORD_W'(1) << pos);
          res_num_d = ENTRY_W'({row_q, pos}) + ENTRY_W'(1);
          if (free_cnt_q != '0) free_cnt_d = free_cnt_q - ENTRY_W'(1);
          if (FILL_W'(row_q) >= fill_q) fill_d = FILL_W'(row_q) + FILL_W'(1);
          state_d = S_RESP;
        end else if (row_q == last_row) begin
          res_status_d = bffa_pkg::ST_FULL;
          state_d      = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = next_row;
          row_d     = next_row;
          fresh_d   = (FILL_W'(next_row) >= fill_q);
        end
      end

      S_FCHK: begin
        if (!word[bsel]) begin
          res_status_d = bffa_pkg::ST_ALREADY_FREE;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = word & ~(WORD_W'(1) << bsel);
          if (free_cnt_q < n_q) free_cnt_d = free_cnt_q + ENTRY_W'(1);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d.allocated_number = res_num_q;
          out_d.status           = res_status_q;
          out_d.free_count       = free_cnt_q;
          out_valid_d            = 1'b1;
          state_d                = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= N_RST;
      free_cnt_q  <= N_RST;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      free_cnt_q  <= free_cnt_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    fresh_q      <= fresh_d;
    idx_q        <= idx_d;
    res_num_q    <= res_num_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  // checks
  `BFFA_ASSERT(a_cnt_bound, free_cnt_q <= n_q, "free count above entry count")
  `BFFA_ASSERT(a_no_rw_clash, !(mem_we && mem_re), "map read and write in one cycle")
  `BFFA_ASSERT(a_fill_bound, fill_q <= FILL_W'(WORDS), "fill mark past map end")
  `BFFA_ASSERT(a_write_in_fill, mem_we |-> (FILL_W'(row_q) <= fill_q), "write past fill mark")
  `BFFA_ASSERT_NEXT(a_resp_load, resp_load, out_valid_q && (state_q == S_IDLE), "no response")

endmodule

@@ sim/bffa_alloc_scoreboard_pkg.sv @@
// allocator outcome predictor and response scoreboard for the testbench
`timescale 1ns / 100ps

package bffa_alloc_scoreboard_pkg;
  import bffa_pkg::*;

  class alloc_scoreboard;
    localparam int unsigned CAP = MAX_ENTRIES_DEF;

    bit                 used_map [CAP];
    int unsigned        usable;
    logic [ENTRY_W-1:0] free_left;
    logic [ENTRY_W-1:0] granted_q [$];
    rsp_t               pending_rsps [$];
    int unsigned        mismatches;

    function new();
      mismatches = 0;
      reload(CFG_RESET);
    endfunction

    // entry count write: clamp, clear the map, refill the counter
    function void reload(logic [ENTRY_W-1:0] count);
      usable = (count > CAP) ? CAP : count;
      foreach (used_map[i]) used_map[i] = 1'b0;
      free_left = ENTRY_W'(usable);
      granted_q.delete();
    endfunction

    // work out the response to an accepted request and queue it
    function void note_request(req_t rq);
      rsp_t        ex;
      int unsigned slot;
      int unsigned idx;
      bit          found;
      ex.allocated_number = '0;
      ex.status = ST_OK;
      found = 1'b0;
      slot = 0;
      if (rq.cmd == CMD_ALLOC) begin
        // first fit: lowest clear bit among the usable entries
        for (int unsigned i = 0; i < usable; i++) begin
          if (!used_map[i]) begin
            slot = i;
            found = 1'b1;
            break;
          end
        end
        if (found) begin
          used_map[slot] = 1'b1;
          if (free_left > 0) free_left = free_left - 1'b1;
          ex.allocated_number = ENTRY_W'(slot + 1);
          granted_q.push_back(ENTRY_W'(slot + 1));
        end else begin
          ex.status = ST_FULL;
        end
      end else if (rq.entry_number == '0 || rq.entry_number > usable) begin
        ex.status = ST_RANGE;
      end else begin
        idx = int'(rq.entry_number) - 1;
        if (!used_map[idx]) begin
          ex.status = ST_ALREADY_FREE;
        end else begin
          used_map[idx] = 1'b0;
          if (free_left < usable) free_left = free_left + 1'b1;
          foreach (granted_q[k]) begin
            if (granted_q[k] == rq.entry_number) begin
              granted_q.delete(k);
              break;
            end
          end
        end
      end
      ex.free_count = free_left;
      pending_rsps.push_back(ex);
    endfunction

    // compare a response with the oldest expectation
    function void check_response(rsp_t got);
      rsp_t ex;
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: alloc %0d status %0d count %0d",
                   got.allocated_number, got.status, got.free_count);
        return;
      end
      ex = pending_rsps.pop_front();
      if (got.allocated_number !== ex.allocated_number || got.status !== ex.status ||
          got.free_count !== ex.free_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: expected alloc %0d status %0d count %0d, %s %0d %0d %0d",
                   ex.allocated_number, ex.status, ex.free_count, "got",
                   got.allocated_number, got.status, got.free_count);
      end
    endfunction

    // random entry currently held, for well-formed free requests
    function bit pick_granted(output logic [ENTRY_W-1:0] num);
      num = '0;
      if (granted_q.size() == 0) return 1'b0;
      num = granted_q[$urandom_range(0, granted_q.size() - 1)];
      return 1'b1;
    endfunction

    function bit busy();
      return pending_rsps.size() != 0;
    endfunction
  endclass

endpackage

@@ sim/tb_bitmap_first_fit_allocator_core.sv @@
// testbench top for the bitmap first-fit allocator core
`timescale 1ns / 100ps

module tb_bitmap_first_fit_allocator_core;
  import bffa_pkg::*;
  import bffa_alloc_scoreboard_pkg::*;

  localparam int unsigned CLK_HALF         = 10;
  localparam int unsigned TAIL_CYCLES      = 140;
  localparam int unsigned RANDOM_ITEMS     = 650;
  localparam int unsigned RUN_LIMIT_CYCLES = 1_000_000;
  localparam logic [ENTRY_W-1:0] CNT_TOP   = 14'h3FFF;

  logic clk;
  logic rst_n;
  bit   no_idle;

  alloc_scoreboard sb;

  bffa_cfg_if cfg_if ();
  bffa_req_if req_if ();
  bffa_rsp_if rsp_if ();

  bitmap_first_fit_allocator_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // clock
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one request and note it once accepted
  task automatic send_request(cmd_e c, logic [ENTRY_W-1:0] num);
    int unsigned gap;
    req_t        rq;
    rq.cmd = c;
    rq.entry_number = num;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(rq);
  endtask

  // stop requests until every response is back
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.busy());
  endtask

  // entry count write, only with the block idle
  task automatic write_entry_count(logic [ENTRY_W-1:0] count);
    drain_responses();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= count;
    do @(posedge clk); while (!cfg_if.ready);
    sb.reload(count);
    cfg_if.valid <= 1'b0;
  endtask

  // extremes, both commands and every special outcome
  task automatic run_directed();
    // reset count of 8192
    send_request(CMD_FREE, 14'd0);
    send_request(CMD_FREE, 14'd8192);
    send_request(CMD_FREE, 14'd8193);
    send_request(CMD_FREE, CNT_TOP);
    send_request(CMD_ALLOC, CNT_TOP);
    send_request(CMD_ALLOC, 14'd0);
    send_request(CMD_ALLOC, 14'd5);
    send_request(CMD_FREE, 14'd2);
    send_request(CMD_FREE, 14'd2);
    send_request(CMD_ALLOC, 14'd0);
    // single entry: grant, full, free, out of range
    write_entry_count(14'd1);
    send_request(CMD_ALLOC, 14'd0);
    send_request(CMD_ALLOC, 14'd0);
    send_request(CMD_FREE, 14'd1);
    send_request(CMD_FREE, 14'd2);
    send_request(CMD_FREE, 14'd0);
    // zero count: always full or out of range
    write_entry_count(14'd0);
    send_request(CMD_ALLOC, 14'd0);
    send_request(CMD_FREE, 14'd1);
    // oversized count clamps to the map size
    write_entry_count(CNT_TOP);
    send_request(CMD_ALLOC, 14'd0);
    send_request(CMD_FREE, 14'd8192);
    send_request(CMD_FREE, 14'd8193);
  endtask

  // mostly well-formed alloc/free traffic with some noise
  task automatic run_phase(int unsigned count);
    int unsigned        alloc_pct;
    int unsigned        r;
    logic [ENTRY_W-1:0] num;
    alloc_pct = $urandom_range(35, 80);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) drain_responses();
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_request(CMD_ALLOC, ENTRY_W'($urandom_range(0, CNT_TOP)));
      end else begin
        r = $urandom_range(0, 99);
        if (!(r < 70 && sb.pick_granted(num))) begin
          if (r < 88) num = ENTRY_W'($urandom_range(0, sb.usable + 2));
          else num = ENTRY_W'($urandom_range(0, CNT_TOP));
        end
        send_request(CMD_FREE, num);
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned        total;
    int unsigned        count;
    int unsigned        r;
    logic [ENTRY_W-1:0] entries;
    sb = new();
    no_idle = 1'b0;
    rst_n        <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    total = 0;
    entries = 14'd8192;
    while (total < RANDOM_ITEMS) begin
      count = $urandom_range(40, 80);
      no_idle = ($urandom_range(0, 4) == 0);
      write_entry_count(entries);
      run_phase(count);
      total += count;
      // next entry count: mostly small so the map fills up
      r = $urandom_range(0, 9);
      if (r == 0) entries = 14'd8192;
      else if (r == 1) entries = ENTRY_W'($urandom_range(8193, CNT_TOP));
      else if (r < 5) entries = ENTRY_W'($urandom_range(65, 400));
      else entries = ENTRY_W'($urandom_range(1, 64));
    end

    no_idle = 1'b0;
    drain_responses();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && !sb.busy()) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // response side: random back-pressure, check every accepted response
  initial begin : rsp_sink
    int unsigned stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
      if (stall == 0 && $urandom_range(0, 3) == 0) stall = pick_gap();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // run time limit
  initial begin
    #(RUN_LIMIT_CYCLES * 2 * CLK_HALF);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
